// ----- rtl/rcw_pkg.sv -----
// rcw_pkg: shared types, constants and sine table for the wall texel mapper
// used by rcw_tile_div and raycast_wall_texel_mapper; depends on nothing
`default_nettype none

package rcw_pkg;

    localparam int SCREEN_W   = 1024;
    localparam int SCREEN_H   = 512;
    localparam int ANGLE_BITS = 12;

    localparam int COL_W      = 11;
    localparam int ROW_W      = 10;
    localparam int DIST_W     = 24;
    localparam int ANG_W      = 12;
    localparam int TEX_W      = 10;
    localparam int TSIZE_W    = 11;
    localparam int POS_W      = 24;
    localparam int TILE_W     = 8;
    localparam int MMW_W      = 11;
    localparam int MMH_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int FRAC_BITS  = 28;
    localparam int SIN_W      = 16;
    localparam int SEG_SHIFT  = ANGLE_BITS - 6;

    // wall height numerator SCREEN_H * 2^14 and its width
    localparam int HN_W = $clog2(SCREEN_H + 1) + 14;
    localparam logic [HN_W-1:0] HEIGHT_NUM = HN_W'(SCREEN_H) << 14;

    // for drawn pixels the texel row quotient is below texture height
    localparam int TQ_W = TSIZE_W;
    localparam int DD_W = HN_W + TQ_W;

    // pipeline stage map
    localparam int ST_SPAN  = HN_W;
    localparam int ST_MUL   = HN_W + 1;
    localparam int ST_TDIV0 = HN_W + 2;
    localparam int ST_LAST  = ST_TDIV0 + TQ_W;
    localparam int NSTAGE   = ST_LAST + 1;

    // player term divider: (pos + tile*256 - 128) << 20 over tile
    localparam int NUMER_W = POS_W + 1;
    localparam int DIVD_W  = NUMER_W + FRAC_BITS - 8;
    localparam int CNT_W   = $clog2(DIVD_W + 1);

    localparam logic [ANGLE_BITS-2:0] QSIZE = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] QTURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    localparam logic [14:0] QSINE [17] = '{
        15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
        15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
        15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_W,
        REG_TEX_H,
        REG_PLAYER_X,
        REG_PLAYER_Y,
        REG_TILE,
        REG_MM_W,
        REG_MM_H
    } cfg_reg_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [DIST_W-1:0] distance;
        logic              side;
        logic [ANG_W-1:0]  cast_angle;
    } pixel_t;

    typedef struct packed {
        logic              draw;
        logic [COL_W-1:0]  out_column;
        logic [ROW_W-1:0]  out_row;
        logic [TEX_W-1:0]  texel_x;
        logic [TEX_W-1:0]  texel_y;
    } texel_t;

    typedef struct packed {
        logic                 busy;
        logic [FRAC_BITS-1:0] q_x;
        logic [FRAC_BITS-1:0] q_y;
    } tile_q_t;

    // first quadrant with linear interpolation, p in 0 .. QSIZE
    function automatic logic [14:0] quarter_value(input logic [ANGLE_BITS-2:0] p);
        logic [ANGLE_BITS-2:0]  idx_w;
        logic [4:0]             idx;
        logic [SEG_SHIFT-1:0]   fr;
        logic [14:0]            lo;
        logic [14:0]            hi;
        logic [14+SEG_SHIFT:0]  prod;
        idx_w = p >> SEG_SHIFT;
        idx   = idx_w[4:0];
        fr    = p[SEG_SHIFT-1:0];
        if (idx_w >= (ANGLE_BITS-1)'(16)) begin
            return QSINE[16];
        end
        lo   = QSINE[idx];
        hi   = QSINE[5'(idx + 5'd1)];
        prod = (15+SEG_SHIFT)'(hi - lo) * (15+SEG_SHIFT)'(fr);
        return 15'(lo + 15'(prod >> SEG_SHIFT));
    endfunction

    function automatic logic signed [SIN_W-1:0] sine_of(input logic [ANGLE_BITS-1:0] a);
        logic [ANGLE_BITS-2:0]    p;
        logic [14:0]              v;
        logic signed [SIN_W-1:0]  sv;
        p  = {1'b0, a[ANGLE_BITS-3:0]};
        v  = quarter_value(a[ANGLE_BITS-2] ? (ANGLE_BITS-1)'(QSIZE - p) : p);
        sv = $signed({1'b0, v});
        return a[ANGLE_BITS-1] ? -sv : sv;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rcw_tile_div.sv -----
// rcw_tile_div: bit-serial divider for the player position term over tile size
// restarts after reset and every register write; depends on rcw_pkg
`default_nettype none

module rcw_tile_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        restart,
    input  wire logic [rcw_pkg::POS_W-1:0]   player_x,
    input  wire logic [rcw_pkg::POS_W-1:0]   player_y,
    input  wire logic [rcw_pkg::TILE_W-1:0]  tile_size,
    output rcw_pkg::tile_q_t                 result
);

    logic                                start_reg;
    logic [rcw_pkg::CNT_W-1:0]           cnt_reg;
    logic [rcw_pkg::DIVD_W-1:0]          dx_reg, dy_reg;
    logic [rcw_pkg::TILE_W-1:0]          rx_reg, ry_reg;
    logic [rcw_pkg::FRAC_BITS-1:0]       qx_reg, qy_reg;

    logic [rcw_pkg::TILE_W-1:0]          tile_eff;
    logic [rcw_pkg::NUMER_W-1:0]         nx, ny;
    logic [rcw_pkg::TILE_W:0]            rx_t, ry_t;
    logic                                gex, gey;
    logic [rcw_pkg::TILE_W-1:0]          rx_next, ry_next;

    assign tile_eff = (tile_size == '0) ? rcw_pkg::TILE_W'(1) : tile_size;
    assign nx = rcw_pkg::NUMER_W'(player_x) + rcw_pkg::NUMER_W'({tile_eff, 8'b0})
              - rcw_pkg::NUMER_W'(128);
    assign ny = rcw_pkg::NUMER_W'(player_y) + rcw_pkg::NUMER_W'({tile_eff, 8'b0})
              - rcw_pkg::NUMER_W'(128);

    // one quotient bit per cycle for each position
    assign rx_t    = {rx_reg, dx_reg[rcw_pkg::DIVD_W-1]};
    assign ry_t    = {ry_reg, dy_reg[rcw_pkg::DIVD_W-1]};
    assign gex     = rx_t >= {1'b0, tile_eff};
    assign gey     = ry_t >= {1'b0, tile_eff};
    assign rx_next = gex ? rcw_pkg::TILE_W'(rx_t - {1'b0, tile_eff}) : rx_t[rcw_pkg::TILE_W-1:0];
    assign ry_next = gey ? rcw_pkg::TILE_W'(ry_t - {1'b0, tile_eff}) : ry_t[rcw_pkg::TILE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            start_reg <= restart;
            if (start_reg)
            begin
                cnt_reg <= rcw_pkg::CNT_W'(rcw_pkg::DIVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
        begin
            dx_reg <= {nx, (rcw_pkg::DIVD_W - rcw_pkg::NUMER_W)'(0)};
            dy_reg <= {ny, (rcw_pkg::DIVD_W - rcw_pkg::NUMER_W)'(0)};
            rx_reg <= '0;
            ry_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dx_reg <= dx_reg << 1;
            dy_reg <= dy_reg << 1;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            qx_reg <= {qx_reg[rcw_pkg::FRAC_BITS-2:0], gex};
            qy_reg <= {qy_reg[rcw_pkg::FRAC_BITS-2:0], gey};
        end
    end

    assign result.busy = restart || start_reg || (cnt_reg != '0);
    assign result.q_x  = qx_reg;
    assign result.q_y  = qy_reg;

endmodule

`default_nettype wire

// ----- rtl/raycast_wall_texel_mapper.sv -----
// raycast_wall_texel_mapper: per-pixel wall span test and texel coordinates
// depends on rcw_pkg and rcw_tile_div
//
//   port group   dir   handshake                 payload
//   pixel        in    pixel_valid/pixel_stall   rcw_pkg::pixel_t
//   texel        out   texel_valid/texel_stall   rcw_pkg::texel_t
//   cfg          in    cfg_write                 cfg_index, cfg_data
//
// one pixel per cycle while pixel_stall is low; the wall height and texel row
// dividers each produce one quotient bit per stage
// after reset and after each register write the input stalls while the
// serial tile divider runs
// a two-entry output register and skid stage keep the input open while a
// result waits; the pipeline holds only when both are full
`default_nettype none

module raycast_wall_texel_mapper (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             pixel_valid,
    output logic                                  pixel_stall,
    input  wire rcw_pkg::pixel_t                  pixel,
    output logic                                  texel_valid,
    input  wire logic                             texel_stall,
    output rcw_pkg::texel_t                       texel,
    input  wire logic                             cfg_write,
    input  wire logic [rcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NS  = rcw_pkg::NSTAGE;
    localparam int HW  = rcw_pkg::HN_W;
    localparam int QW  = rcw_pkg::TQ_W;
    localparam int DW  = rcw_pkg::DD_W;
    localparam int FB  = rcw_pkg::FRAC_BITS;
    localparam int L   = rcw_pkg::ST_LAST;
    localparam int PS  = rcw_pkg::ST_SPAN - 1;

    // configuration registers
    logic [rcw_pkg::TSIZE_W-1:0]  tex_w_reg, tex_h_reg;
    logic [rcw_pkg::POS_W-1:0]    px_reg, py_reg;
    logic [rcw_pkg::TILE_W-1:0]   tile_reg;
    logic [rcw_pkg::MMW_W-1:0]    mmw_reg;
    logic [rcw_pkg::MMH_W-1:0]    mmh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_w_reg <= rcw_pkg::TSIZE_W'(64);
            tex_h_reg <= rcw_pkg::TSIZE_W'(64);
            px_reg    <= '0;
            py_reg    <= '0;
            tile_reg  <= rcw_pkg::TILE_W'(64);
            mmw_reg   <= '0;
            mmh_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (rcw_pkg::cfg_reg_t'(cfg_index))
                rcw_pkg::REG_TEX_W:    tex_w_reg <= cfg_data[rcw_pkg::TSIZE_W-1:0];
                rcw_pkg::REG_TEX_H:    tex_h_reg <= cfg_data[rcw_pkg::TSIZE_W-1:0];
                rcw_pkg::REG_PLAYER_X: px_reg    <= cfg_data[rcw_pkg::POS_W-1:0];
                rcw_pkg::REG_PLAYER_Y: py_reg    <= cfg_data[rcw_pkg::POS_W-1:0];
                rcw_pkg::REG_TILE:     tile_reg  <= cfg_data[rcw_pkg::TILE_W-1:0];
                rcw_pkg::REG_MM_W:     mmw_reg   <= cfg_data[rcw_pkg::MMW_W-1:0];
                rcw_pkg::REG_MM_H:     mmh_reg   <= cfg_data[rcw_pkg::MMH_W-1:0];
                default: ;
            endcase
        end
    end

    rcw_pkg::tile_q_t tile_q;

    rcw_tile_div u_tile_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_write),
        .player_x  (px_reg),
        .player_y  (py_reg),
        .tile_size (tile_reg),
        .result    (tile_q)
    );

    // pipeline registers, one entry per stage
    logic                               v_reg    [0:NS-1], v_next    [0:NS-1];
    logic [rcw_pkg::COL_W-1:0]          col_reg  [0:NS-1], col_next  [0:NS-1];
    logic [rcw_pkg::ROW_W-1:0]          row_reg  [0:NS-1], row_next  [0:NS-1];
    logic [rcw_pkg::DIST_W-1:0]         dist_reg [0:NS-1], dist_next [0:NS-1];
    logic                               side_reg [0:NS-1], side_next [0:NS-1];
    logic signed [rcw_pkg::SIN_W-1:0]   sel_reg  [0:NS-1], sel_next  [0:NS-1];
    logic                               flip_reg [0:NS-1], flip_next [0:NS-1];
    logic [FB-1:0]                      wt_reg   [0:NS-1], wt_next   [0:NS-1];
    logic [FB-1:0]                      frac_reg [0:NS-1], frac_next [0:NS-1];
    logic [rcw_pkg::TSIZE_W-1:0]        txr_reg  [0:NS-1], txr_next  [0:NS-1];
    logic [rcw_pkg::TEX_W-1:0]          tx_reg   [0:NS-1], tx_next   [0:NS-1];
    logic [rcw_pkg::DIST_W-1:0]         hrem_reg [0:NS-1], hrem_next [0:NS-1];
    logic [HW-1:0]                      hq_reg   [0:NS-1], hq_next   [0:NS-1];
    logic [HW-1:0]                      hgt_reg  [0:NS-1], hgt_next  [0:NS-1];
    logic                               drw_reg  [0:NS-1], drw_next  [0:NS-1];
    logic [HW-1:0]                      n_reg    [0:NS-1], n_next    [0:NS-1];
    logic [DW-1:0]                      dd_reg   [0:NS-1], dd_next   [0:NS-1];
    logic [HW-1:0]                      trem_reg [0:NS-1], trem_next [0:NS-1];
    logic [QW-1:0]                      tlow_reg [0:NS-1], tlow_next [0:NS-1];
    logic [QW-1:0]                      yq_reg   [0:NS-1], yq_next   [0:NS-1];
    logic [rcw_pkg::TEX_W-1:0]          ty_reg   [0:NS-1], ty_next   [0:NS-1];

    logic adv;

    // restoring division steps
    function automatic logic hdiv_ge(input logic [rcw_pkg::DIST_W-1:0] rem, input logic b,
                                     input logic [rcw_pkg::DIST_W-1:0] d);
        return {rem, b} >= {1'b0, d};
    endfunction

    function automatic logic [rcw_pkg::DIST_W-1:0] hdiv_rem(
        input logic [rcw_pkg::DIST_W-1:0] rem, input logic b,
        input logic [rcw_pkg::DIST_W-1:0] d);
        logic [rcw_pkg::DIST_W:0] r;
        r = {rem, b};
        return (r >= {1'b0, d}) ? rcw_pkg::DIST_W'(r - {1'b0, d}) : r[rcw_pkg::DIST_W-1:0];
    endfunction

    function automatic logic tdiv_ge(input logic [HW-1:0] rem, input logic b,
                                     input logic [HW-1:0] d);
        return {rem, b} >= {1'b0, d};
    endfunction

    function automatic logic [HW-1:0] tdiv_rem(input logic [HW-1:0] rem, input logic b,
                                               input logic [HW-1:0] d);
        logic [HW:0] r;
        r = {rem, b};
        return (r >= {1'b0, d}) ? HW'(r - {1'b0, d}) : r[HW-1:0];
    endfunction

    function automatic logic hbit(input int k);
        return (k >= 0 && k < HW) ? rcw_pkg::HEIGHT_NUM[k] : 1'b0;
    endfunction

    // entry: sine and cosine of the ray angle
    logic [rcw_pkg::ANGLE_BITS-1:0]       ang_in;
    logic signed [rcw_pkg::SIN_W-1:0]     sn_in, cs_in;

    assign ang_in = rcw_pkg::ANGLE_BITS'(pixel.cast_angle);
    assign sn_in  = rcw_pkg::sine_of(ang_in);
    assign cs_in  = rcw_pkg::sine_of(rcw_pkg::ANGLE_BITS'(ang_in + rcw_pkg::QTURN));

    // texel column path, stages one to four
    logic signed [rcw_pkg::DIST_W+rcw_pkg::SIN_W:0]  wt_prod;
    logic [FB-1:0]                                   wt_calc;
    logic [FB-1:0]                                   frac_calc;
    logic [FB+rcw_pkg::TSIZE_W-1:0]                  txr_prod;
    logic [rcw_pkg::TSIZE_W-1:0]                     txr_calc;
    logic signed [rcw_pkg::TSIZE_W+1:0]              tw_m1, tx_s, tx_c;
    logic [rcw_pkg::TEX_W-1:0]                       tx_calc;

    assign wt_prod   = $signed({1'b0, dist_reg[0]}) * sel_reg[0];
    assign wt_calc   = wt_prod[FB-1:0];
    assign frac_calc = FB'((side_reg[1] ? tile_q.q_x : tile_q.q_y) + wt_reg[1]);
    assign txr_prod  = (FB+rcw_pkg::TSIZE_W)'(frac_reg[2]) * (FB+rcw_pkg::TSIZE_W)'(tex_w_reg);
    assign txr_calc  = txr_prod[FB+rcw_pkg::TSIZE_W-1:FB];

    always_comb
    begin
        tw_m1 = $signed({2'b0, tex_w_reg}) - 13'sd1;
        tx_s  = flip_reg[3] ? tw_m1 - $signed({2'b0, txr_reg[3]})
                            : $signed({2'b0, txr_reg[3]});
        tx_c  = tx_s;
        if (tx_c > tw_m1)
        begin
            tx_c = tw_m1;
        end
        if (tx_c < 0)
        begin
            tx_c = '0;
        end
        tx_calc = tx_c[rcw_pkg::TEX_W-1:0];
    end

    // wall span from the finished height quotient
    logic [HW-1:0]   hgt_s, half_s;
    logic signed [HW:0] start_s;
    logic [HW:0]     end_s, rowx;
    logic            in_span, col_ok, in_map, draw_s;
    logic [HW:0]     n_wide;

    always_comb
    begin
        hgt_s   = (dist_reg[PS] == '0) ? rcw_pkg::HEIGHT_NUM : hq_reg[PS];
        half_s  = hgt_s >> 1;
        start_s = $signed((HW+1)'(rcw_pkg::SCREEN_H / 2)) - $signed({1'b0, half_s});
        end_s   = (HW+1)'(rcw_pkg::SCREEN_H / 2) + {1'b0, half_s};
        rowx    = (HW+1)'(row_reg[PS]);
        in_span = ($signed(rowx) >= start_s) && (rowx < end_s)
               && (row_reg[PS] < rcw_pkg::ROW_W'(rcw_pkg::SCREEN_H));
        col_ok  = col_reg[PS] < rcw_pkg::COL_W'(rcw_pkg::SCREEN_W);
        in_map  = (row_reg[PS] < mmh_reg) && (col_reg[PS] < mmw_reg);
        draw_s  = in_span && col_ok && !in_map && (hgt_s != '0);
        // offset from the unclamped span start
        n_wide  = rowx + {1'b0, half_s} - (HW+1)'(rcw_pkg::SCREEN_H / 2);
    end

    // stage zero takes the pixel
    always_comb
    begin
        v_next[0]    = pixel_valid && !tile_q.busy;
        col_next[0]  = pixel.column;
        row_next[0]  = pixel.row;
        dist_next[0] = pixel.distance;
        side_next[0] = pixel.side;
        sel_next[0]  = pixel.side ? cs_in : sn_in;
        flip_next[0] = pixel.side ? (sn_in > 0) : (cs_in < 0);
        wt_next[0]   = '0;
        frac_next[0] = '0;
        txr_next[0]  = '0;
        tx_next[0]   = '0;
        hrem_next[0] = hdiv_rem('0, hbit(HW-1), pixel.distance);
        hq_next[0]   = HW'(hdiv_ge('0, hbit(HW-1), pixel.distance));
        hgt_next[0]  = '0;
        drw_next[0]  = 1'b0;
        n_next[0]    = '0;
        dd_next[0]   = '0;
        trem_next[0] = '0;
        tlow_next[0] = '0;
        yq_next[0]   = '0;
        ty_next[0]   = '0;
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_stage
        always_comb
        begin
            v_next[s]    = v_reg[s-1];
            col_next[s]  = col_reg[s-1];
            row_next[s]  = row_reg[s-1];
            dist_next[s] = dist_reg[s-1];
            side_next[s] = side_reg[s-1];
            sel_next[s]  = sel_reg[s-1];
            flip_next[s] = flip_reg[s-1];
            wt_next[s]   = wt_reg[s-1];
            frac_next[s] = frac_reg[s-1];
            txr_next[s]  = txr_reg[s-1];
            tx_next[s]   = tx_reg[s-1];
            hrem_next[s] = hrem_reg[s-1];
            hq_next[s]   = hq_reg[s-1];
            hgt_next[s]  = hgt_reg[s-1];
            drw_next[s]  = drw_reg[s-1];
            n_next[s]    = n_reg[s-1];
            dd_next[s]   = dd_reg[s-1];
            trem_next[s] = trem_reg[s-1];
            tlow_next[s] = tlow_reg[s-1];
            yq_next[s]   = yq_reg[s-1];
            ty_next[s]   = ty_reg[s-1];

            if (s == 1)
            begin
                wt_next[s] = wt_calc;
            end
            if (s == 2)
            begin
                frac_next[s] = frac_calc;
            end
            if (s == 3)
            begin
                txr_next[s] = txr_calc;
            end
            if (s == 4)
            begin
                tx_next[s] = tx_calc;
            end
            if (s < HW)
            begin
                hrem_next[s] = hdiv_rem(hrem_reg[s-1], hbit(HW-1-s), dist_reg[s-1]);
                hq_next[s]   = {hq_reg[s-1][HW-2:0],
                                hdiv_ge(hrem_reg[s-1], hbit(HW-1-s), dist_reg[s-1])};
            end
            if (s == rcw_pkg::ST_SPAN)
            begin
                hgt_next[s] = hgt_s;
                drw_next[s] = draw_s;
                n_next[s]   = n_wide[HW-1:0];
            end
            if (s == rcw_pkg::ST_MUL)
            begin
                dd_next[s] = DW'(n_reg[s-1]) * DW'(tex_h_reg);
            end
            if (s == rcw_pkg::ST_TDIV0)
            begin
                trem_next[s] = tdiv_rem(dd_reg[s-1][DW-1:QW], dd_reg[s-1][QW-1], hgt_reg[s-1]);
                tlow_next[s] = {dd_reg[s-1][QW-2:0], 1'b0};
                yq_next[s]   = QW'(tdiv_ge(dd_reg[s-1][DW-1:QW], dd_reg[s-1][QW-1],
                                           hgt_reg[s-1]));
            end
            if (s > rcw_pkg::ST_TDIV0 && s < L)
            begin
                trem_next[s] = tdiv_rem(trem_reg[s-1], tlow_reg[s-1][QW-1], hgt_reg[s-1]);
                tlow_next[s] = tlow_reg[s-1] << 1;
                yq_next[s]   = {yq_reg[s-1][QW-2:0],
                                tdiv_ge(trem_reg[s-1], tlow_reg[s-1][QW-1], hgt_reg[s-1])};
            end
            if (s == L)
            begin
                drw_next[s] = drw_reg[s-1] && (yq_reg[s-1] < tex_h_reg);
                ty_next[s]  = (drw_reg[s-1] && (yq_reg[s-1] < tex_h_reg))
                            ? yq_reg[s-1][rcw_pkg::TEX_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= v_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                col_reg[i]  <= col_next[i];
                row_reg[i]  <= row_next[i];
                dist_reg[i] <= dist_next[i];
                side_reg[i] <= side_next[i];
                sel_reg[i]  <= sel_next[i];
                flip_reg[i] <= flip_next[i];
                wt_reg[i]   <= wt_next[i];
                frac_reg[i] <= frac_next[i];
                txr_reg[i]  <= txr_next[i];
                tx_reg[i]   <= tx_next[i];
                hrem_reg[i] <= hrem_next[i];
                hq_reg[i]   <= hq_next[i];
                hgt_reg[i]  <= hgt_next[i];
                drw_reg[i]  <= drw_next[i];
                n_reg[i]    <= n_next[i];
                dd_reg[i]   <= dd_next[i];
                trem_reg[i] <= trem_next[i];
                tlow_reg[i] <= tlow_next[i];
                yq_reg[i]   <= yq_next[i];
                ty_reg[i]   <= ty_next[i];
            end
        end
    end

    // output register plus skid entry
    rcw_pkg::texel_t  tail_item;
    rcw_pkg::texel_t  out_reg, out_next, skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    assign tail_item.draw       = drw_reg[L];
    assign tail_item.out_column = col_reg[L];
    assign tail_item.out_row    = row_reg[L];
    assign tail_item.texel_x    = tx_reg[L];
    assign tail_item.texel_y    = ty_reg[L];

    assign adv = !skid_valid_reg;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || !texel_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = tail_item;
                out_valid_next = v_reg[L];
            end
        end
        else if (v_reg[L] && adv)
        begin
            skid_next       = tail_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign pixel_stall = !adv || tile_q.busy;
    assign texel_valid = out_valid_reg;
    assign texel       = out_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a transaction while the output register is empty");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        tile_q.busy |-> pixel_stall)
        else $error("pixel accepted while the tile divider is running");

    a_draw_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (texel_valid && texel.draw) |->
            (texel.out_column < rcw_pkg::COL_W'(rcw_pkg::SCREEN_W)))
        else $error("draw flagged for a column past the screen");

    a_no_draw_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (texel_valid && !texel.draw) |-> (texel.texel_y == '0))
        else $error("texel row not cleared on a pixel that does not draw");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench for raycast_wall_texel_mapper: directed and random pixels under
// bursty input and patterned output stalls; depends on rcw_pkg and the rtl
`default_nettype none

module testbench;

    localparam int                            IDLE_LIMIT = 4000;
    localparam int                            DRAIN_WAIT = 80;
    localparam logic [rcw_pkg::CFG_IDX_W-1:0] REG_NONE   = 3'd7;

    logic clk;
    logic rst_n;
    logic pixel_valid;
    logic pixel_stall;
    rcw_pkg::pixel_t pixel;
    logic texel_valid;
    logic texel_stall;
    rcw_pkg::texel_t texel;
    logic cfg_write;
    logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rcw_pkg::CFG_DATA_W-1:0] cfg_data;

    raycast_wall_texel_mapper u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .texel_valid (texel_valid),
        .texel_stall (texel_stall),
        .texel       (texel),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    class texel_scoreboard;
        rcw_pkg::texel_t  pending_texels[$];
        int               errors;
        longint           tex_w, tex_h, pos_x, pos_y, tile_sz, mm_w, mm_h;

        function void set_defaults();
            tex_w = 64; tex_h = 64; pos_x = 0; pos_y = 0;
            tile_sz = 64; mm_w = 0; mm_h = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [rcw_pkg::CFG_IDX_W-1:0] idx,
                                logic [rcw_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                rcw_pkg::REG_TEX_W:    tex_w   = longint'(v[10:0]);
                rcw_pkg::REG_TEX_H:    tex_h   = longint'(v[10:0]);
                rcw_pkg::REG_PLAYER_X: pos_x   = longint'(v);
                rcw_pkg::REG_PLAYER_Y: pos_y   = longint'(v);
                rcw_pkg::REG_TILE:     tile_sz = longint'(v[7:0]);
                rcw_pkg::REG_MM_W:     mm_w    = longint'(v[10:0]);
                rcw_pkg::REG_MM_H:     mm_h    = longint'(v[9:0]);
                default: ;
            endcase
        endfunction

        function longint quadrant_sine(longint p);
            longint tbl[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                                12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
            longint idx, fr;
            idx = p >> 6;
            fr  = p & 63;
            if (idx >= 16)
                return tbl[16];
            return tbl[idx] + (((tbl[idx+1] - tbl[idx]) * fr) >> 6);
        endfunction

        function longint sine(longint a);
            longint quad, p;
            a    = a & 4095;
            quad = a >> 10;
            p    = a & 1023;
            case (quad)
                0: return quadrant_sine(p);
                1: return quadrant_sine(1024 - p);
                2: return -quadrant_sine(p);
                default: return -quadrant_sine(1024 - p);
            endcase
        endfunction

        function rcw_pkg::texel_t map_pixel(rcw_pkg::pixel_t p);
            longint sn, cs, tile, ppos, num, sum, frac, tx;
            longint height, start, stop, first, ty, row, col;
            bit     draw;
            rcw_pkg::texel_t r;
            row  = longint'(p.row);
            col  = longint'(p.column);
            sn   = sine(longint'(p.cast_angle));
            cs   = sine(longint'(p.cast_angle) + 1024);
            tile = (tile_sz == 0) ? 1 : tile_sz;
            ppos = p.side ? pos_x : pos_y;
            num  = (ppos + (tile << 8) - 128) << 20;
            sum  = num / tile + longint'(p.distance) * (p.side ? cs : sn);
            frac = sum & ((longint'(1) << 28) - 1);
            tx   = (frac * tex_w) >> 28;
            if ((p.side == 0 && cs < 0) || (p.side == 1 && sn > 0))
                tx = tex_w - tx - 1;
            if (tx > tex_w - 1)
                tx = tex_w - 1;
            if (tx < 0)
                tx = 0;
            // zero distance saturates the wall height
            if (p.distance == 0)
                height = longint'(rcw_pkg::SCREEN_H) << 14;
            else
                height = (longint'(rcw_pkg::SCREEN_H) << 14) / longint'(p.distance);
            start = rcw_pkg::SCREEN_H / 2 - height / 2;
            stop  = rcw_pkg::SCREEN_H / 2 + height / 2;
            first = (start < 0) ? 0 : start;
            if (stop > rcw_pkg::SCREEN_H)
                stop = rcw_pkg::SCREEN_H;
            draw = 1;
            ty   = 0;
            if (col >= rcw_pkg::SCREEN_W || row < first || row >= stop)
                draw = 0;
            if (row < mm_h && col < mm_w)
                draw = 0;
            if (draw && height > 0)
            begin
                ty = ((row - start) * tex_h) / height;
                if (ty < 0 || ty >= tex_h)
                    draw = 0;
            end
            else
                draw = 0;
            if (!draw)
                ty = 0;
            r.draw       = draw;
            r.out_column = p.column;
            r.out_row    = p.row;
            r.texel_x    = tx[9:0];
            r.texel_y    = ty[9:0];
            return r;
        endfunction

        function void note_pixel(rcw_pkg::pixel_t p);
            pending_texels.push_back(map_pixel(p));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_texel(rcw_pkg::texel_t t);
            rcw_pkg::texel_t e;
            if (pending_texels.size() == 0)
            begin
                report("unexpected transaction, column", longint'(t.out_column), -1);
                return;
            end
            e = pending_texels.pop_front();
            if (t.draw !== e.draw)
                report("draw", longint'(t.draw), longint'(e.draw));
            if (t.out_column !== e.out_column)
                report("out_column", longint'(t.out_column), longint'(e.out_column));
            if (t.out_row !== e.out_row)
                report("out_row", longint'(t.out_row), longint'(e.out_row));
            if (t.texel_x !== e.texel_x)
                report("texel_x", longint'(t.texel_x), longint'(e.texel_x));
            if (t.texel_y !== e.texel_y)
                report("texel_y", longint'(t.texel_y), longint'(e.texel_y));
        endtask
    endclass

    texel_scoreboard sb;
    int idle_cycles;
    int stall_period, stall_duty, stall_count;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // output side: patterned stalls, monitors and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
                sb.note_pixel(pixel);
            if (texel_valid && !texel_stall)
                sb.check_texel(texel);
            if ((pixel_valid && !pixel_stall) || (texel_valid && !texel_stall) || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("raycast_wall_texel_mapper regression: fail");
                $finish;
            end
            if (stall_count >= stall_period)
            begin
                stall_count  <= 0;
                stall_period <= $urandom_range(4, 40);
                stall_duty   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
            end
            else
            begin
                stall_count <= stall_count + 1;
            end
            texel_stall <= (stall_count < stall_duty);
        end
    end

    task write_reg(logic [rcw_pkg::CFG_IDX_W-1:0] idx, int v);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= rcw_pkg::CFG_DATA_W'(v);
        sb.write_reg(idx, rcw_pkg::CFG_DATA_W'(v));
        @(posedge clk);
        cfg_write <= 0;
    endtask

    task settle();
        while (sb.pending_texels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task send_pixel(rcw_pkg::pixel_t p);
        pixel_valid <= 1;
        pixel       <= p;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    task pause_sender(int n);
        pixel_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    function rcw_pkg::pixel_t make_pixel(int column, int row, int distance, int side,
                                         int angle);
        rcw_pkg::pixel_t p;
        p.column     = rcw_pkg::COL_W'(column);
        p.row        = rcw_pkg::ROW_W'(row);
        p.distance   = rcw_pkg::DIST_W'(distance);
        p.side       = 1'(side);
        p.cast_angle = rcw_pkg::ANG_W'(angle);
        return p;
    endfunction

    function rcw_pkg::pixel_t random_pixel();
        rcw_pkg::pixel_t p;
        int sel;
        p.column = ($urandom_range(0, 9) == 0) ? rcw_pkg::COL_W'($urandom_range(0, 2047))
                                               : rcw_pkg::COL_W'($urandom_range(0, 1023));
        p.row    = ($urandom_range(0, 9) == 0) ? rcw_pkg::ROW_W'($urandom_range(0, 1023))
                                               : rcw_pkg::ROW_W'($urandom_range(0, 511));
        sel = $urandom_range(0, 19);
        if (sel == 0)
            p.distance = '0;
        else if (sel < 3)
            p.distance = rcw_pkg::DIST_W'($urandom_range(0, 24'hFFFFFF));
        else
            p.distance = rcw_pkg::DIST_W'($urandom_range(3000, 200000));
        p.side       = 1'($urandom_range(0, 1));
        p.cast_angle = rcw_pkg::ANG_W'($urandom_range(0, 4095));
        return p;
    endfunction

    task random_phase(int count, bit hold_midway);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_pixel(random_pixel());
                sent++;
            end
            if (hold_midway && sent >= count / 2)
            begin
                hold_midway = 0;
                pixel_valid <= 0;
                while (sb.pending_texels.size() != 0)
                    @(posedge clk);
            end
            else if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 20));
        end
        pixel_valid <= 0;
    endtask

    initial
    begin
        int angles[6] = '{0, 512, 1024, 2048, 3072, 4095};
        sb = new();
        sb.set_defaults();
        rst_n        = 0;
        pixel_valid  = 0;
        pixel        = '0;
        texel_stall  = 0;
        cfg_write    = 0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_cycles  = 0;
        stall_period = 10;
        stall_duty   = 0;
        stall_count  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, zero distance, off-screen columns, quadrants
        send_pixel(make_pixel(0, 0, 0, 0, 0));
        send_pixel(make_pixel(2047, 1023, 24'hFFFFFF, 1, 4095));
        send_pixel(make_pixel(1023, 255, 1, 0, 1024));
        send_pixel(make_pixel(1024, 256, 16384, 1, 2048));
        send_pixel(make_pixel(5, 511, 16384, 0, 3072));
        send_pixel(make_pixel(5, 512, 16384, 1, 512));
        foreach (angles[i])
        begin
            send_pixel(make_pixel(100, 200, 20000, 0, angles[i]));
            send_pixel(make_pixel(100, 300, 12000, 1, angles[i]));
        end
        send_pixel(make_pixel(700, 10, 4000, 1, 777));
        pause_sender(3);
        send_pixel(make_pixel(1500, 10, 4000, 0, 1777));
        pixel_valid <= 0;
        settle();

        random_phase(100, 1);
        settle();

        write_reg(rcw_pkg::REG_TEX_W, 1);
        write_reg(rcw_pkg::REG_TEX_H, 1);
        write_reg(rcw_pkg::REG_PLAYER_X, 24'hFFFFFF);
        write_reg(rcw_pkg::REG_PLAYER_Y, 0);
        write_reg(rcw_pkg::REG_TILE, 1);
        write_reg(rcw_pkg::REG_MM_W, 2047);
        write_reg(rcw_pkg::REG_MM_H, 1023);
        write_reg(REG_NONE, $urandom);
        random_phase(60, 0);
        settle();

        write_reg(rcw_pkg::REG_TEX_W, 1024);
        write_reg(rcw_pkg::REG_TEX_H, 1024);
        write_reg(rcw_pkg::REG_PLAYER_X, $urandom_range(0, 24'hFFFFFF));
        write_reg(rcw_pkg::REG_PLAYER_Y, 24'hFFFFFF);
        write_reg(rcw_pkg::REG_TILE, 255);
        write_reg(rcw_pkg::REG_MM_W, 100);
        write_reg(rcw_pkg::REG_MM_H, 50);
        random_phase(110, 0);
        settle();

        // zero texture width, zero tile and oversized texture height
        write_reg(rcw_pkg::REG_TEX_W, 0);
        write_reg(rcw_pkg::REG_TEX_H, 2047);
        write_reg(rcw_pkg::REG_PLAYER_X, $urandom_range(0, 24'hFFFFFF));
        write_reg(rcw_pkg::REG_PLAYER_Y, $urandom_range(0, 24'hFFFFFF));
        write_reg(rcw_pkg::REG_TILE, 0);
        write_reg(rcw_pkg::REG_MM_W, 0);
        write_reg(rcw_pkg::REG_MM_H, 0);
        random_phase(100, 0);
        settle();

        write_reg(rcw_pkg::REG_TEX_W, 2047);
        write_reg(rcw_pkg::REG_TEX_H, 0);
        random_phase(60, 0);
        settle();

        write_reg(rcw_pkg::REG_TEX_W, $urandom_range(1, 1024));
        write_reg(rcw_pkg::REG_TEX_H, $urandom_range(1, 1024));
        write_reg(rcw_pkg::REG_PLAYER_X, $urandom_range(0, 24'hFFFFFF));
        write_reg(rcw_pkg::REG_PLAYER_Y, $urandom_range(0, 24'hFFFFFF));
        write_reg(rcw_pkg::REG_TILE, $urandom_range(1, 255));
        write_reg(rcw_pkg::REG_MM_W, $urandom_range(0, 2047));
        write_reg(rcw_pkg::REG_MM_H, $urandom_range(0, 1023));
        random_phase(150, 1);

        while (sb.pending_texels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("raycast_wall_texel_mapper regression: pass");
        else
            $display("raycast_wall_texel_mapper regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/rcw_pkg.sv
rtl/rcw_tile_div.sv
rtl/raycast_wall_texel_mapper.sv
bench/testbench.sv
